// ===== rtl/core/bdq_pkg.sv =====
// Shared types, codes and widths of the bounded deque core.
// Used by the cell, the controller and the top level; depends on nothing.
package bdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VAL_W = 32;
    localparam int REQ_W = 3;
    localparam int STATUS_W = 3;
    localparam int IN_TDATA_W = ((REQ_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((STATUS_W + VAL_W + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] REQ_ADD_REAR = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DEL_REAR = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_VALUE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DUMP_REV = 3'd5;
    localparam logic [REQ_W-1:0] REQ_DUMP_FWD = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOW_EMPTY = 3'd4;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_REAR,
        CMD_SHIFT_R,
        CMD_ROT_R,
        CMD_POP_REAR,
        CMD_SHIFT_L,
        CMD_ROT_L
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t               cmd;
        logic signed [VAL_W-1:0] din;
    } cell_ctl_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] head_val;
        logic signed [VAL_W-1:0] tail_val;
    } chain_stat_t;

endpackage

// ===== rtl/core/bdq_cell.sv =====
// One storage cell of the deque chain: a value and its valid flag.
// Depends on bdq_pkg for the command type and value width.
module bdq_cell
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  bdq_pkg::cell_ctl_t                ctl,
    input  logic signed [bdq_pkg::VAL_W-1:0]  left_val,
    input  logic                              left_vld,
    input  logic signed [bdq_pkg::VAL_W-1:0]  right_val,
    input  logic                              right_vld,
    input  logic signed [bdq_pkg::VAL_W-1:0]  wrap_val,
    output logic signed [bdq_pkg::VAL_W-1:0]  val,
    output logic                              vld,
    output logic                              tail
);

    logic signed [bdq_pkg::VAL_W-1:0] val_reg;
    logic signed [bdq_pkg::VAL_W-1:0] val_next;
    logic                             vld_reg;
    logic                             vld_next;

    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        unique case (ctl.cmd)
            bdq_pkg::CMD_HOLD:
            begin
            end
            bdq_pkg::CMD_PUSH_REAR:
            begin
                if (!vld_reg && left_vld)
                begin
                    val_next = ctl.din;
                    vld_next = 1'b1;
                end
            end
            bdq_pkg::CMD_SHIFT_R:
            begin
                val_next = left_val;
                vld_next = left_vld;
            end
            bdq_pkg::CMD_ROT_R:
            begin
                if (vld_reg)
                begin
                    val_next = left_val;
                end
            end
            bdq_pkg::CMD_POP_REAR:
            begin
                if (vld_reg && !right_vld)
                begin
                    vld_next = 1'b0;
                end
            end
            bdq_pkg::CMD_SHIFT_L:
            begin
                val_next = right_val;
                vld_next = right_vld;
            end
            bdq_pkg::CMD_ROT_L:
            begin
                if (vld_reg)
                begin
                    val_next = right_vld ? right_val : wrap_val;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign vld = vld_reg;
    assign tail = vld_reg && !right_vld;

endmodule

// ===== rtl/core/bdq_ctrl.sv =====
// Request sequencer, element count and registered result beat of the deque.
// Depends on bdq_pkg; drives the cell chain through one broadcast command.
module bdq_ctrl
#(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bdq_pkg::REQ_W-1:0]         req_type,
    input  logic signed [bdq_pkg::VAL_W-1:0]  value,
    input  bdq_pkg::chain_stat_t              chain,
    output bdq_pkg::cell_ctl_t                ctl,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bdq_pkg::STATUS_W-1:0]      status,
    output logic signed [bdq_pkg::VAL_W-1:0]  value_res,
    output logic                              last
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic { S_IDLE, S_RUN } state_t;
    typedef enum logic [1:0] { JOB_DEL_VALUE, JOB_DUMP_FWD, JOB_DUMP_REV } job_t;

    state_t                           state_reg, state_next;
    job_t                             job_reg, job_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [CW-1:0]                    steps_reg, steps_next;
    logic                             found_reg, found_next;
    logic signed [bdq_pkg::VAL_W-1:0] key_reg, key_next;
    logic                             out_valid_reg, out_valid_next;
    logic [bdq_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;
    logic signed [bdq_pkg::VAL_W-1:0] out_value_reg, out_value_next;
    logic                             out_last_reg, out_last_next;

    logic out_free;
    logic accept;
    logic is_full;
    logic is_empty;
    logic final_step;
    logic drop;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept = in_valid && in_ready;
    assign is_full = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign final_step = (steps_reg == CW'(1));
    assign drop = (state_reg == S_RUN) && (job_reg == JOB_DEL_VALUE) && !found_reg
                  && (chain.head_val == key_reg);

    always_comb
    begin
        state_next = state_reg;
        job_next = job_reg;
        count_next = count_reg;
        steps_next = steps_reg;
        found_next = found_reg;
        key_next = key_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_value_next = out_value_reg;
        out_last_next = out_last_reg;
        ctl.cmd = bdq_pkg::CMD_HOLD;
        ctl.din = value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_value_next = '0;
                    out_last_next = 1'b1;
                    unique case (req_type)
                        bdq_pkg::REQ_ADD_REAR, bdq_pkg::REQ_ADD_FRONT:
                        begin
                            out_valid_next = 1'b1;
                            if (is_full)
                            begin
                                out_status_next = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.cmd = (req_type == bdq_pkg::REQ_ADD_REAR) ?
                                          bdq_pkg::CMD_PUSH_REAR : bdq_pkg::CMD_SHIFT_R;
                                count_next = count_reg + CW'(1);
                                out_status_next = bdq_pkg::ST_OK;
                            end
                        end
                        bdq_pkg::REQ_DEL_REAR, bdq_pkg::REQ_DEL_FRONT:
                        begin
                            out_valid_next = 1'b1;
                            if (is_empty)
                            begin
                                out_status_next = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctl.cmd = (req_type == bdq_pkg::REQ_DEL_REAR) ?
                                          bdq_pkg::CMD_POP_REAR : bdq_pkg::CMD_SHIFT_L;
                                count_next = count_reg - CW'(1);
                                out_status_next = (count_reg == CW'(1)) ?
                                                  bdq_pkg::ST_NOW_EMPTY : bdq_pkg::ST_OK;
                            end
                        end
                        bdq_pkg::REQ_DEL_VALUE, bdq_pkg::REQ_DUMP_REV,
                        bdq_pkg::REQ_DUMP_FWD:
                        begin
                            if (is_empty)
                            begin
                                out_valid_next = 1'b1;
                                out_status_next = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_RUN;
                                steps_next = count_reg;
                                found_next = 1'b0;
                                key_next = value;
                                if (req_type == bdq_pkg::REQ_DEL_VALUE)
                                begin
                                    job_next = JOB_DEL_VALUE;
                                end
                                else if (req_type == bdq_pkg::REQ_DUMP_FWD)
                                begin
                                    job_next = JOB_DUMP_FWD;
                                end
                                else
                                begin
                                    job_next = JOB_DUMP_REV;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                if (out_free)
                begin
                    steps_next = steps_reg - CW'(1);
                    unique case (job_reg)
                        JOB_DEL_VALUE:
                        begin
                            if (drop)
                            begin
                                ctl.cmd = bdq_pkg::CMD_SHIFT_L;
                                found_next = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                ctl.cmd = bdq_pkg::CMD_ROT_L;
                            end
                            if (final_step)
                            begin
                                out_valid_next = 1'b1;
                                out_value_next = '0;
                                out_last_next = 1'b1;
                                if (!found_next)
                                begin
                                    out_status_next = bdq_pkg::ST_NOT_FOUND;
                                end
                                else if (count_next == '0)
                                begin
                                    out_status_next = bdq_pkg::ST_NOW_EMPTY;
                                end
                                else
                                begin
                                    out_status_next = bdq_pkg::ST_OK;
                                end
                            end
                        end
                        JOB_DUMP_FWD:
                        begin
                            ctl.cmd = bdq_pkg::CMD_ROT_L;
                            out_valid_next = 1'b1;
                            out_status_next = bdq_pkg::ST_OK;
                            out_value_next = chain.head_val;
                            out_last_next = final_step;
                        end
                        JOB_DUMP_REV:
                        begin
                            ctl.cmd = bdq_pkg::CMD_ROT_R;
                            out_valid_next = 1'b1;
                            out_status_next = bdq_pkg::ST_OK;
                            out_value_next = chain.tail_val;
                            out_last_next = final_step;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (final_step)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg <= JOB_DEL_VALUE;
            count_reg <= '0;
            steps_reg <= '0;
            found_reg <= 1'b0;
            key_reg <= '0;
            out_valid_reg <= 1'b0;
            out_status_reg <= '0;
            out_value_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg <= job_next;
            count_reg <= count_next;
            steps_reg <= steps_next;
            found_reg <= found_next;
            key_reg <= key_next;
            out_valid_reg <= out_valid_next;
            out_status_reg <= out_status_next;
            out_value_reg <= out_value_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status = out_status_reg;
    assign value_res = out_value_reg;
    assign last = out_last_reg;

    // The element count never passes the capacity of the chain.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count beyond capacity");

    // A multi-step request always has steps left while it runs.
    a_steps_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (steps_reg != '0))
        else $error("running with no steps left");

    // Only dump beats come without a last mark, and they carry status ok.
    a_non_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (out_status_reg == bdq_pkg::ST_OK))
        else $error("non-final beat with a status other than ok");

    // A delete by value never removes more than one element.
    a_single_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && job_reg == JOB_DEL_VALUE && found_reg)
        |=> (count_reg == $past(count_reg)))
        else $error("second element removed in one delete by value");

endmodule

// ===== rtl/core/bounded_deque_with_delete_by_value_core.sv =====
// Top level of the bounded deque core: the cell chain and its controller.
// Depends on bdq_pkg, bdq_cell and bdq_ctrl.
//
// The deque holds up to DEPTH signed 32-bit values in a row of cells, front
// in the first cell. Requests are taken one at a time on the slave side. Adds
// and deletes at either end give one result beat. A delete by value and a
// dump rotate the whole sequence once around the chain, one element per
// cycle while the master side does not stall. A dump of a non-empty deque
// gives one beat per element with tlast on the final one; every other
// defined request gives a single beat with tlast set, and an unused request
// code gives none. A request is taken again as soon as the last beat of the
// previous one is in the output register and that register is free.
module bounded_deque_with_delete_by_value_core
#(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0 up: req_type[2:0], value[34:3], zero fill.
    input  logic [bdq_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // Fields from bit 0 up: status[2:0], value_res[34:3], zero fill.
    output logic [bdq_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast
);

    localparam int PAD_W = bdq_pkg::OUT_TDATA_W - bdq_pkg::STATUS_W - bdq_pkg::VAL_W;

    logic [bdq_pkg::REQ_W-1:0]        req_type;
    logic signed [bdq_pkg::VAL_W-1:0] value;
    logic [bdq_pkg::STATUS_W-1:0]     status;
    logic signed [bdq_pkg::VAL_W-1:0] value_res;

    bdq_pkg::cell_ctl_t               ctl;
    bdq_pkg::chain_stat_t             chain;

    logic signed [bdq_pkg::VAL_W-1:0] vals [DEPTH];
    logic [DEPTH-1:0]                 vlds;
    logic [DEPTH-1:0]                 tails;
    logic signed [bdq_pkg::VAL_W-1:0] tail_val;
    logic signed [bdq_pkg::VAL_W-1:0] chain_in;

    assign req_type = s_tdata[bdq_pkg::REQ_W-1:0];
    assign value = s_tdata[bdq_pkg::REQ_W+bdq_pkg::VAL_W-1:bdq_pkg::REQ_W];

    always_comb
    begin
        tail_val = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_val = tail_val | (tails[i] ? vals[i] : '0);
        end
    end

    assign chain_in = (ctl.cmd == bdq_pkg::CMD_ROT_R) ? tail_val : ctl.din;
    assign chain.head_val = vals[0];
    assign chain.tail_val = tail_val;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [bdq_pkg::VAL_W-1:0] left_val;
        logic                             left_vld;
        logic signed [bdq_pkg::VAL_W-1:0] right_val;
        logic                             right_vld;

        if (i == 0)
        begin : g_first
            assign left_val = chain_in;
            assign left_vld = 1'b1;
        end
        else
        begin : g_mid
            assign left_val = vals[i-1];
            assign left_vld = vlds[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign right_val = '0;
            assign right_vld = 1'b0;
        end
        else
        begin : g_inner
            assign right_val = vals[i+1];
            assign right_vld = vlds[i+1];
        end

        bdq_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .left_val  (left_val),
            .left_vld  (left_vld),
            .right_val (right_val),
            .right_vld (right_vld),
            .wrap_val  (vals[0]),
            .val       (vals[i]),
            .vld       (vlds[i]),
            .tail      (tails[i])
        );
    end

    bdq_ctrl
    #(
        .DEPTH (DEPTH)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .req_type  (req_type),
        .value     (value),
        .chain     (chain),
        .ctl       (ctl),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .value_res (value_res),
        .last      (m_tlast)
    );

    assign m_tdata = {{PAD_W{1'b0}}, value_res, status};

    // Live cells always form one unbroken run starting at the first cell.
    a_vld_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (vlds & (vlds + DEPTH'(1))) == '0)
        else $error("valid cells not packed toward the front");

endmodule

// ===== sim/bounded_deque_with_delete_by_value_core_tb.sv =====
// Self-checking testbench for bounded_deque_with_delete_by_value_core.
// Depends on bdq_pkg and the core. It checks every result beat against a
// queue-based predictor under random idling on both stream sides.
`timescale 1ns / 100ps

module bounded_deque_with_delete_by_value_core_tb;

    import bdq_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int RANDOM_REQUESTS = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * DEPTH + 8;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [REQ_W-1:0]        req;
        logic signed [VAL_W-1:0] value;
        bit                      wait_drain;
    } request_t;

    typedef struct {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    logic signed [VAL_W-1:0] deque_model[$];
    beat_t                   expected_beats[$];
    request_t                pending_requests[$];
    request_t                next_req;
    beat_t                   want;
    bit                      drain_next = 1'b0;
    logic                    drained = 1'b1;
    int                      sent_cnt = 0;
    int                      total_requests = 0;
    int                      idle_cycles = 0;
    int                      mismatch_cnt = 0;

    bounded_deque_with_delete_by_value_core #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push_beat(input logic [STATUS_W-1:0] status,
                                      input logic signed [VAL_W-1:0] value,
                                      input logic last);
        beat_t b;
        b.status = status;
        b.value = value;
        b.last = last;
        expected_beats.push_back(b);
    endfunction

    function automatic logic [STATUS_W-1:0] removal_status();
        return (deque_model.size() == 0) ? ST_NOW_EMPTY : ST_OK;
    endfunction

    function automatic void predict_request(input logic [REQ_W-1:0] req,
                                            input logic signed [VAL_W-1:0] v);
        int hit;
        int n;
        hit = -1;
        n = deque_model.size();
        case (req)
            REQ_ADD_REAR, REQ_ADD_FRONT:
            begin
                if (n >= DEPTH)
                    push_beat(ST_FULL, '0, 1'b1);
                else
                begin
                    if (req == REQ_ADD_REAR)
                        deque_model.push_back(v);
                    else
                        deque_model.push_front(v);
                    push_beat(ST_OK, '0, 1'b1);
                end
            end
            REQ_DEL_REAR, REQ_DEL_FRONT:
            begin
                if (n == 0)
                    push_beat(ST_EMPTY, '0, 1'b1);
                else
                begin
                    if (req == REQ_DEL_REAR)
                        void'(deque_model.pop_back());
                    else
                        void'(deque_model.pop_front());
                    push_beat(removal_status(), '0, 1'b1);
                end
            end
            REQ_DEL_VALUE:
            begin
                if (n == 0)
                    push_beat(ST_EMPTY, '0, 1'b1);
                else
                begin
                    for (int i = 0; i < n; i++)
                        if (hit < 0 && deque_model[i] == v)
                            hit = i;
                    if (hit < 0)
                        push_beat(ST_NOT_FOUND, '0, 1'b1);
                    else
                    begin
                        deque_model.delete(hit);
                        push_beat(removal_status(), '0, 1'b1);
                    end
                end
            end
            REQ_DUMP_REV, REQ_DUMP_FWD:
            begin
                if (n == 0)
                    push_beat(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < n; i++)
                        push_beat(ST_OK,
                                  deque_model[(req == REQ_DUMP_FWD) ? i : n - 1 - i],
                                  i == n - 1);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void add_request(input logic [REQ_W-1:0] req,
                                        input logic signed [VAL_W-1:0] v);
        request_t r;
        r.req = req;
        r.value = v;
        r.wait_drain = drain_next;
        drain_next = 1'b0;
        pending_requests.push_back(r);
        predict_request(req, v);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        if (r < 4)
            return int'($urandom_range(0, 8)) - 4;
        return $urandom;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_delete_value();
        if (deque_model.size() != 0 && $urandom_range(0, 3) != 0)
            return deque_model[$urandom_range(0, deque_model.size() - 1)];
        return pick_value();
    endfunction

    function automatic logic [REQ_W-1:0] pick_add();
        return $urandom_range(0, 1) ? REQ_ADD_FRONT : REQ_ADD_REAR;
    endfunction

    function automatic logic [REQ_W-1:0] pick_dump();
        return $urandom_range(0, 1) ? REQ_DUMP_FWD : REQ_DUMP_REV;
    endfunction

    function automatic void add_delete();
        case ($urandom_range(0, 2))
            0: add_request(REQ_DEL_REAR, pick_value());
            1: add_request(REQ_DEL_FRONT, pick_value());
            default: add_request(REQ_DEL_VALUE, pick_delete_value());
        endcase
    endfunction

    function automatic void add_mixed();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            add_request(pick_add(), pick_value());
        else if (r < 42)
            add_request($urandom_range(0, 1) ? REQ_DEL_FRONT : REQ_DEL_REAR, pick_value());
        else if (r < 62)
            add_request(REQ_DEL_VALUE, pick_delete_value());
        else if (r < 92)
            add_request(pick_dump(), pick_value());
        else
            add_request(REQ_UNUSED, pick_value());
    endfunction

    function automatic int sender_idle_pct();
        if (sent_cnt < total_requests / 3)
            return 12;
        if (sent_cnt < 2 * total_requests / 3)
            return 52;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (sent_cnt < total_requests / 3)
            return 52;
        if (sent_cnt < 2 * total_requests / 3)
            return 12;
        return 0;
    endfunction

    function automatic void flag_error(input string msg);
        if (mismatch_cnt < MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
        mismatch_cnt++;
    endfunction

    initial
    begin
        int target;
        int unsigned kind;

        add_request(REQ_DEL_REAR, 32'sd0);
        add_request(REQ_DEL_FRONT, 32'sd0);
        add_request(REQ_DEL_VALUE, 32'sd7);
        add_request(REQ_DUMP_REV, 32'sd0);
        add_request(REQ_DUMP_FWD, 32'sd0);
        add_request(REQ_UNUSED, -32'sd1);
        add_request(REQ_ADD_REAR, 32'sh7FFF_FFFF);
        add_request(REQ_ADD_FRONT, 32'sh8000_0000);
        add_request(REQ_ADD_REAR, 32'sd0);
        add_request(REQ_ADD_REAR, -32'sd1);
        add_request(REQ_ADD_FRONT, 32'sd1);
        drain_next = 1'b1;
        add_request(REQ_DUMP_FWD, 32'sd0);
        add_request(REQ_DUMP_REV, 32'sd0);
        add_request(REQ_DEL_VALUE, 32'sh7FFF_FFFF);
        add_request(REQ_DEL_VALUE, 32'sd12345);
        add_request(REQ_DEL_FRONT, 32'sd0);
        add_request(REQ_DEL_REAR, 32'sd0);
        add_request(REQ_DEL_VALUE, 32'sd0);
        add_request(REQ_DEL_VALUE, 32'sh8000_0000);
        add_request(REQ_ADD_FRONT, 32'sd5);
        add_request(REQ_DEL_REAR, 32'sd0);
        add_request(REQ_ADD_REAR, 32'sd9);
        add_request(REQ_DEL_FRONT, 32'sd0);

        target = pending_requests.size() + RANDOM_REQUESTS;
        while (pending_requests.size() < target)
        begin
            drain_next = ($urandom_range(0, 14) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 3)
            begin
                while (deque_model.size() < DEPTH)
                    add_request(pick_add(), pick_value());
                repeat ($urandom_range(1, 2))
                    add_request(pick_add(), pick_value());
                add_request(pick_dump(), pick_value());
                repeat ($urandom_range(1, 4))
                    add_request(REQ_DEL_VALUE, pick_delete_value());
            end
            else if (kind < 5)
            begin
                while (deque_model.size() != 0)
                    add_delete();
                repeat ($urandom_range(1, 2))
                    add_delete();
                add_request(pick_dump(), pick_value());
            end
            else
                repeat (8)
                    add_mixed();
        end

        total_requests = pending_requests.size();
        deque_model.delete();
        expected_beats.delete();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || s_tvalid || !drained)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_beats.size() != 0)
            flag_error($sformatf("%0d expected result beats never arrived",
                                 expected_beats.size()));
        if (mismatch_cnt == 0)
            $display("** bounded_deque_with_delete_by_value_core: PASSED **");
        else
            $display("** bounded_deque_with_delete_by_value_core: FAILED **");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            sent_cnt <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                sent_cnt <= sent_cnt + 1;
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() != 0
                    && $urandom_range(0, 99) >= sender_idle_pct()
                    && (!pending_requests[0].wait_drain || (!s_tvalid && drained)))
                begin
                    next_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(IN_TDATA_W - REQ_W - VAL_W){1'b0}},
                                next_req.value, next_req.req};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drained <= 1'b1;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                    flag_error($sformatf("unexpected beat: status %0d value %0d last %0b",
                                         m_tdata[STATUS_W-1:0],
                                         $signed(m_tdata[STATUS_W+VAL_W-1:STATUS_W]),
                                         m_tlast));
                else
                begin
                    want = expected_beats.pop_front();
                    if (m_tdata[STATUS_W-1:0] !== want.status
                        || m_tdata[STATUS_W+VAL_W-1:STATUS_W] !== want.value
                        || m_tlast !== want.last)
                        flag_error($sformatf(
                            "beat mismatch: expected status %0d value %0d last %0b, got status %0d value %0d last %0b",
                            want.status, want.value, want.last,
                            m_tdata[STATUS_W-1:0],
                            $signed(m_tdata[STATUS_W+VAL_W-1:STATUS_W]), m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                predict_request(s_tdata[REQ_W-1:0], s_tdata[REQ_W+VAL_W-1:REQ_W]);
            drained <= (expected_beats.size() == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
                $display("** bounded_deque_with_delete_by_value_core: FAILED **");
                $finish;
            end
        end
    end

endmodule
